@@ src/quaternion_alu_defines.svh @@
`ifndef QUATERNION_ALU_DEFINES_SVH
`define QUATERNION_ALU_DEFINES_SVH

// implication checked on the same edge
`define QALU_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication checked a fixed number of edges later
`define QALU_CHECK_LATER(lbl, ante, n, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

@@ src/qalu_pkg.sv @@
`default_nettype none

package qalu_pkg;

   localparam logic [2:0] CMD_ADD  = 3'd0;
   localparam logic [2:0] CMD_MUL  = 3'd1;
   localparam logic [2:0] CMD_CONJ = 3'd2;
   localparam logic [2:0] CMD_NORM = 3'd3;
   localparam logic [2:0] CMD_UNIT = 3'd4;

   localparam int PROD_W   = 64;
   localparam int PAIR_W   = 65;
   localparam int SUM_W    = 66;
   localparam int CLAMP_W  = 67;
   localparam int RAD_W    = 66;
   localparam int ROOT_W   = 33;
   localparam int SREM_W   = 35;
   localparam int SQ_STEPS = 33;

   localparam logic signed [CLAMP_W-1:0] S32_MAX_W = 67'sd2147483647;
   localparam logic signed [CLAMP_W-1:0] S32_MIN_W = -67'sd2147483648;

   // product signs per Hamilton row, bit t set means subtract
   localparam logic [3:0] NEG_ROW [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

   typedef logic signed [31:0] comp_type;

   typedef struct packed {
      logic [2:0] cmd;
      comp_type   a_real;
      comp_type   a_i;
      comp_type   a_j;
      comp_type   a_k;
      comp_type   b_real;
      comp_type   b_i;
      comp_type   b_j;
      comp_type   b_k;
   } req_type;

   typedef struct packed {
      comp_type r_real;
      comp_type r_i;
      comp_type r_j;
      comp_type r_k;
      logic     saturated;
      logic     zero_norm;
   } rsp_type;

   typedef struct packed {
      comp_type value;
      logic     sat;
   } clamp_type;

   function automatic clamp_type clamp32(input logic signed [CLAMP_W-1:0] v);
      clamp_type c;
      c.sat = 1'b1;
      if (v > S32_MAX_W) begin
         c.value = 32'sh7fffffff;
      end else if (v < S32_MIN_W) begin
         c.value = 32'sh80000000;
      end else begin
         c.value = comp_type'(v[31:0]);
         c.sat   = 1'b0;
      end
      return c;
   endfunction

   function automatic rsp_type pack_rsp(input comp_type [3:0] r, input logic sat,
                                        input logic zn);
      rsp_type w;
      w.r_real    = r[0];
      w.r_i       = r[1];
      w.r_j       = r[2];
      w.r_k       = r[3];
      w.saturated = sat;
      w.zero_norm = zn;
      return w;
   endfunction

endpackage

`default_nettype wire

@@ src/quaternion_alu.sv @@
`default_nettype none

// Quaternion ALU, signed fixed point with FRAC_BITS fraction bits: add, Hamilton
// product, conjugate, norm and unit normalisation of A. A word is taken on every
// clock edge with start high (busy never rises), and its result leaves on rsp_word
// with a one-cycle rsp_valid strobe, in order, whatever the opcode. Every word
// passes the norm path: an input register, the product stages (products, pair sums,
// row totals), a load register and a 33-stage square root pipeline (one root bit
// per stage), a load register and a FRAC_BITS + 1 stage divider (one quotient bit
// per stage), then the output register. The strobe cannot be held off, so the
// receiver must take every result in the cycle it appears.

`include "quaternion_alu_defines.svh"

module quaternion_alu import qalu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int LATENCY   = FRAC_BITS + 41;

   typedef struct packed {
      logic                            valid;
      logic [2:0]                      cmd;
      comp_type [3:0]                  a;
      rsp_type                         word;
      logic [RAD_W-1:0]                rad;
      logic [ROOT_W-1:0]               root;
      logic [SREM_W-1:0]               rem;
   } sq_type;

   typedef struct packed {
      logic                            valid;
      logic [2:0]                      cmd;
      rsp_type                         word;
      logic [ROOT_W-1:0]               n;
      logic [3:0]                      neg;
      logic [3:0]                      m0;
      logic [3:0][ROOT_W-1:0]          rem;
      logic [3:0][DIV_STEPS-1:0]       quo;
   } div_type;

   assign busy = 1'b0;

   // input register
   logic    in_valid_ff;
   req_type in_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      in_word_ff <= req_word;
   end

   // products; row 0 squares A for the norm
   logic                     m_valid_ff;
   logic [2:0]               m_cmd_ff;
   comp_type [3:0]           m_a_ff;
   rsp_type                  m_simple_ff;
   logic signed [PROD_W-1:0] m_prod_ff [4][4];

   comp_type [3:0]           qa;
   comp_type [3:0]           qb;
   logic                     m_sq;
   rsp_type                  m_simple_in;
   logic signed [PROD_W-1:0] m_prod_in [4][4];

   always_comb begin
      comp_type        y;
      comp_type [3:0]  r;
      clamp_type       c;
      logic            sat;
      c    = '0;
      qa   = {in_word_ff.a_k, in_word_ff.a_j, in_word_ff.a_i, in_word_ff.a_real};
      qb   = {in_word_ff.b_k, in_word_ff.b_j, in_word_ff.b_i, in_word_ff.b_real};
      m_sq = (in_word_ff.cmd == CMD_NORM) || (in_word_ff.cmd == CMD_UNIT);
      for (int row = 0; row < 4; row++) begin
         for (int t = 0; t < 4; t++) begin
            y = (row == 0 && m_sq) ? qa[t] : qb[2'(row ^ t)];
            m_prod_in[row][t] = PROD_W'(qa[t]) * PROD_W'(y);
         end
      end
      r   = '0;
      sat = 1'b0;
      case (in_word_ff.cmd)
         CMD_ADD: begin
            for (int t = 0; t < 4; t++) begin
               c    = clamp32(CLAMP_W'(qa[t]) + CLAMP_W'(qb[t]));
               r[t] = c.value;
               sat  = sat | c.sat;
            end
         end
         CMD_CONJ: begin
            r[0] = qa[0];
            for (int t = 1; t < 4; t++) begin
               c    = clamp32(-CLAMP_W'(qa[t]));
               r[t] = c.value;
               sat  = sat | c.sat;
            end
         end
         default: begin
            r   = '0;
            sat = 1'b0;
         end
      endcase
      m_simple_in = pack_rsp(r, sat, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= in_valid_ff;
      end
      m_cmd_ff    <= in_word_ff.cmd;
      m_a_ff      <= qa;
      m_simple_ff <= m_simple_in;
      m_prod_ff   <= m_prod_in;
   end

   // pair sums
   logic                     p_valid_ff;
   logic [2:0]               p_cmd_ff;
   comp_type [3:0]           p_a_ff;
   rsp_type                  p_simple_ff;
   logic signed [PAIR_W-1:0] p_pair_ff [4][2];
   logic signed [PAIR_W-1:0] p_pair_in [4][2];

   always_comb begin
      logic signed [PAIR_W-1:0] term [2];
      logic                     sq;
      sq = (m_cmd_ff == CMD_NORM) || (m_cmd_ff == CMD_UNIT);
      for (int row = 0; row < 4; row++) begin
         for (int h = 0; h < 2; h++) begin
            for (int e = 0; e < 2; e++) begin
               if (NEG_ROW[row][2*h+e] && !(row == 0 && sq)) begin
                  term[e] = -PAIR_W'(m_prod_ff[row][2*h+e]);
               end else begin
                  term[e] = PAIR_W'(m_prod_ff[row][2*h+e]);
               end
            end
            p_pair_in[row][h] = term[0] + term[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= m_valid_ff;
      end
      p_cmd_ff    <= m_cmd_ff;
      p_a_ff      <= m_a_ff;
      p_simple_ff <= m_simple_ff;
      p_pair_ff   <= p_pair_in;
   end

   // row totals
   logic                    t_valid_ff;
   logic [2:0]              t_cmd_ff;
   comp_type [3:0]          t_a_ff;
   rsp_type                 t_simple_ff;
   logic signed [SUM_W-1:0] t_tot_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else begin
         t_valid_ff <= p_valid_ff;
      end
      t_cmd_ff    <= p_cmd_ff;
      t_a_ff      <= p_a_ff;
      t_simple_ff <= p_simple_ff;
      for (int row = 0; row < 4; row++) begin
         t_tot_ff[row] <= SUM_W'(p_pair_ff[row][0]) + SUM_W'(p_pair_ff[row][1]);
      end
   end

   // product scaling, then square root of the sum of squares
   sq_type sq_ff [SQ_STEPS+1];
   sq_type sq_load_in;

   always_comb begin
      comp_type [3:0] r;
      clamp_type      c;
      logic           sat;
      sat = 1'b0;
      for (int row = 0; row < 4; row++) begin
         c      = clamp32(CLAMP_W'(t_tot_ff[row] >>> FRAC_BITS));
         r[row] = c.value;
         sat    = sat | c.sat;
      end
      sq_load_in.valid = t_valid_ff && !reset;
      sq_load_in.cmd   = t_cmd_ff;
      sq_load_in.a     = t_a_ff;
      case (t_cmd_ff)
         CMD_ADD:  sq_load_in.word = t_simple_ff;
         CMD_CONJ: sq_load_in.word = t_simple_ff;
         CMD_MUL:  sq_load_in.word = pack_rsp(r, sat, 1'b0);
         default:  sq_load_in.word = '0;
      endcase
      sq_load_in.rad  = RAD_W'(t_tot_ff[0]);
      sq_load_in.root = '0;
      sq_load_in.rem  = '0;
   end

   always_ff @(posedge clock) begin
      sq_ff[0] <= sq_load_in;
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      sq_type nxt_in;

      always_comb begin
         logic [SREM_W+1:0] cur;
         logic [SREM_W+1:0] trial;
         cur    = {sq_ff[k].rem, sq_ff[k].rad[RAD_W-1 -: 2]};
         trial  = {2'b00, sq_ff[k].root, 2'b01};
         nxt_in = sq_ff[k];
         nxt_in.valid = sq_ff[k].valid && !reset;
         nxt_in.rad = {sq_ff[k].rad[RAD_W-3:0], 2'b00};
         if (cur >= trial) begin
            nxt_in.rem  = SREM_W'(cur - trial);
            nxt_in.root = {sq_ff[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            nxt_in.rem  = SREM_W'(cur);
            nxt_in.root = {sq_ff[k].root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         sq_ff[k+1] <= nxt_in;
      end
   end

   // norm result, then component / norm
   div_type dv_ff [DIV_STEPS+1];
   div_type dv_load_in;

   always_comb begin
      sq_type          s;
      logic [31:0]     mag;
      s = sq_ff[SQ_STEPS];
      dv_load_in.valid = s.valid && !reset;
      dv_load_in.cmd   = s.cmd;
      dv_load_in.word  = s.word;
      dv_load_in.n     = s.root;
      if (s.cmd == CMD_NORM) begin
         if (s.root > ROOT_W'(32'h7fffffff)) begin
            dv_load_in.word.r_real    = 32'sh7fffffff;
            dv_load_in.word.saturated = 1'b1;
         end else begin
            dv_load_in.word.r_real = comp_type'(s.root[31:0]);
         end
      end
      if (s.cmd == CMD_UNIT) begin
         dv_load_in.word.zero_norm = (s.root == '0);
      end
      for (int t = 0; t < 4; t++) begin
         dv_load_in.neg[t] = s.a[t][31];
         mag = s.a[t][31] ? 32'(-s.a[t]) : 32'(s.a[t]);
         dv_load_in.m0[t]  = mag[0];
         dv_load_in.rem[t] = ROOT_W'(mag >> 1);
         dv_load_in.quo[t] = '0;
      end
   end

   always_ff @(posedge clock) begin
      dv_ff[0] <= dv_load_in;
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      div_type nxt_in;

      always_comb begin
         logic [ROOT_W:0] cur;
         logic            in_bit;
         nxt_in = dv_ff[j];
         nxt_in.valid = dv_ff[j].valid && !reset;
         for (int t = 0; t < 4; t++) begin
            in_bit = (j == 0) ? dv_ff[j].m0[t] : 1'b0;
            cur    = {dv_ff[j].rem[t], in_bit};
            if (cur >= {1'b0, dv_ff[j].n}) begin
               nxt_in.rem[t] = ROOT_W'(cur - {1'b0, dv_ff[j].n});
               nxt_in.quo[t] = {dv_ff[j].quo[t][DIV_STEPS-2:0], 1'b1};
            end else begin
               nxt_in.rem[t] = ROOT_W'(cur);
               nxt_in.quo[t] = {dv_ff[j].quo[t][DIV_STEPS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         dv_ff[j+1] <= nxt_in;
      end
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_word_ff;
   rsp_type rsp_word_in;

   always_comb begin
      div_type        d;
      comp_type [3:0] r;
      comp_type       q;
      d = dv_ff[DIV_STEPS];
      for (int t = 0; t < 4; t++) begin
         q    = comp_type'(32'(d.quo[t]));
         r[t] = d.neg[t] ? -q : q;
      end
      if (d.cmd == CMD_UNIT && d.n != '0) begin
         rsp_word_in = pack_rsp(r, 1'b0, 1'b0);
      end else begin
         rsp_word_in = d.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_ff[DIV_STEPS].valid;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `QALU_CHECK_LATER(a_latency, start && !busy, LATENCY, rsp_valid, "word lost in pipeline")
   `QALU_CHECK(a_no_phantom, rsp_valid, $past(start && !busy, LATENCY), "result without word")
   `QALU_CHECK(a_zero_norm, rsp_valid && rsp_word.zero_norm, !rsp_word.saturated && rsp_word.r_real == 0 && rsp_word.r_i == 0 && rsp_word.r_j == 0 && rsp_word.r_k == 0, "zero norm result not clear")

endmodule

`default_nettype wire
